// ===== hdl/mwm_pkg.sv =====
// shared constants, types and the arctangent table of the mecanum wheel mixer
`timescale 1ns / 1ps
`default_nettype none
package mwm_pkg;

  localparam int CMD_WIDTH     = 16;
  localparam int HEADING_WIDTH = 16;
  localparam int FRAC_BITS     = CMD_WIDTH - 2;
  localparam int ONE           = 2 ** FRAC_BITS;

  // cordic datapath
  localparam int GUARD        = 8;
  localparam int GAIN_BITS    = 30;
  localparam logic [GAIN_BITS-1:0] INV_GAIN = GAIN_BITS'(652032874);
  localparam int PRE_SHIFT    = GAIN_BITS - GUARD;
  localparam int CORDIC_STEPS = 16;
  localparam int PHASE_W      = 32;
  localparam int CW           = CMD_WIDTH + GUARD + 4;
  localparam int PROD_W       = CMD_WIDTH + GAIN_BITS + 1;

  // mixing and normalization
  localparam int ROT_W = CMD_WIDTH + 2;
  localparam int MIX_W = CMD_WIDTH + 3;
  localparam int MAG_W = CMD_WIDTH + 2;
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int NUM_W = MAG_W + QUO_W;

  typedef logic signed [CMD_WIDTH-1:0] cmd_t;
  typedef logic [HEADING_WIDTH-1:0]    heading_t;

  // arctangent of 2^-i as a fraction of a full turn of 2^32
  function automatic logic [PHASE_W-1:0] atan_turn(input int i);
    logic [PHASE_W-1:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933405;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335086;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41721;
      15:      a = 32'd20860;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mwm_in_if.sv =====
// command channel of the mecanum wheel mixer
`timescale 1ns / 1ps
`default_nettype none
interface mwm_in_if
  import mwm_pkg::*;
;
  logic     valid;
  logic     ready;
  cmd_t     strafe_cmd;
  cmd_t     forward_cmd;
  cmd_t     turn_cmd;
  heading_t heading;
  logic     field_centric;

  modport source (output valid, strafe_cmd, forward_cmd, turn_cmd, heading, field_centric,
                  input ready);
  modport sink   (input valid, strafe_cmd, forward_cmd, turn_cmd, heading, field_centric,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/mwm_out_if.sv =====
// wheel speed channel of the mecanum wheel mixer
`timescale 1ns / 1ps
`default_nettype none
interface mwm_out_if
  import mwm_pkg::*;
;
  logic valid;
  logic ready;
  cmd_t front_left_speed;
  cmd_t rear_left_speed;
  cmd_t front_right_speed;
  cmd_t rear_right_speed;

  modport source (output valid, front_left_speed, rear_left_speed, front_right_speed,
                  rear_right_speed, input ready);
  modport sink   (input valid, front_left_speed, rear_left_speed, front_right_speed,
                  rear_right_speed, output ready);
endinterface
`default_nettype wire

// ===== hdl/mecanum_wheel_mixer.sv =====
// mecanum wheel mixer: field-centric rotation, wheel mixing and normalization pipeline
//
// Takes one command word per clock. A command passes 40 registers on its way out:
// the input register, prescale multiply, quadrant fold, 16 cordic stages, guard-bit
// rounding, mixing, magnitudes, max search, divider load, 15 restoring divider stages
// (one quotient bit per stage for all four wheels at once) and the output register.
// Throughput is one word per cycle; the whole pipeline advances when the output register
// is empty or being taken, so a stalled output holds every stage and in_ch.ready drops.
// Commands and speeds are signed Q2.14, heading is a fraction of a full turn with
// counterclockwise rotation for increasing values. Speeds are bounded to one in magnitude.
`timescale 1ns / 1ps
`default_nettype none
module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  mwm_in_if.sink      in_ch,
  mwm_out_if.source   out_ch
);

  // stage map
  localparam int S_IN   = 0;                 // input register
  localparam int S_PROD = 1;                 // prescale products
  localparam int S_C0   = 2;                 // cordic stage 0 (after quadrant fold)
  localparam int S_ROT  = S_C0 + CORDIC_STEPS + 1;
  localparam int S_MIX  = S_ROT + 1;
  localparam int S_MAG  = S_MIX + 1;
  localparam int S_MAX  = S_MAG + 1;
  localparam int S_D0   = S_MAX + 1;         // divider stage 0
  localparam int S_OUT  = S_D0 + QUO_W + 1;
  localparam int DEPTH  = S_OUT;

  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(ONE);

  // global advance: everything moves when the output register can take a word
  logic out_valid_r;
  logic en;
  logic in_fire;
  logic [DEPTH-1:0] vld_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_fire};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  // input register
  cmd_t     x0_r, y0_r, r0_r;
  heading_t h0_r;
  logic     fc0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= in_ch.strafe_cmd;
      y0_r  <= in_ch.forward_cmd;
      r0_r  <= in_ch.turn_cmd;
      h0_r  <= in_ch.heading;
      fc0_r <= in_ch.field_centric;
    end
  end

  // prescale by the inverse cordic gain, quadrant and residual angle
  logic signed [PROD_W-1:0]  px_nxt, py_nxt, px1_r, py1_r;
  logic [PHASE_W-1:0]        phase, qsum;
  logic [1:0]                q_nxt, q1_r;
  logic [PHASE_W-1:0]        z_nxt, z1_r;
  cmd_t                      x1_r, y1_r, r1_r;
  logic                      fc1_r;

  always_comb begin
    px_nxt = PROD_W'(x0_r) * $signed({1'b0, INV_GAIN});
    py_nxt = PROD_W'(y0_r) * $signed({1'b0, INV_GAIN});
    phase  = {h0_r, {(PHASE_W-HEADING_WIDTH){1'b0}}};
    qsum   = phase + (PHASE_W'(1) << (PHASE_W - 3));
    q_nxt  = qsum[PHASE_W-1 -: 2];
    z_nxt  = phase - {q_nxt, {(PHASE_W-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= px_nxt;
      py1_r <= py_nxt;
      q1_r  <= q_nxt;
      z1_r  <= z_nxt;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      r1_r  <= r0_r;
      fc1_r <= fc0_r;
    end
  end

  // round off the prescale and fold the quadrant exactly
  logic signed [PROD_W-1:0] xs, ys;
  logic signed [CW-1:0]     xg, yg, xq, yq;

  always_comb begin
    xs = (px1_r + (PROD_W'(1) << (PRE_SHIFT - 1))) >>> PRE_SHIFT;
    ys = (py1_r + (PROD_W'(1) << (PRE_SHIFT - 1))) >>> PRE_SHIFT;
    xg = xs[CW-1:0];
    yg = ys[CW-1:0];
    case (q1_r)
      2'd1:    begin xq = -yg; yq = xg;  end
      2'd2:    begin xq = -xg; yq = -yg; end
      2'd3:    begin xq = yg;  yq = -xg; end
      default: begin xq = xg;  yq = yg;  end
    endcase
  end

  // cordic rotation stages, raw commands ride along
  logic signed [CW-1:0]      cx_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]      cy_r [0:CORDIC_STEPS];
  logic signed [PHASE_W-1:0] cz_r [0:CORDIC_STEPS];
  cmd_t                      cxr_r [0:CORDIC_STEPS];
  cmd_t                      cyr_r [0:CORDIC_STEPS];
  cmd_t                      crr_r [0:CORDIC_STEPS];
  logic                      cfc_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]      cx_nxt [0:CORDIC_STEPS-1];
  logic signed [CW-1:0]      cy_nxt [0:CORDIC_STEPS-1];
  logic signed [PHASE_W-1:0] cz_nxt [0:CORDIC_STEPS-1];

  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!cz_r[k][PHASE_W-1]) begin
        cx_nxt[k] = cx_r[k] - (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] + (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] - $signed(atan_turn(k));
      end else begin
        cx_nxt[k] = cx_r[k] + (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] - (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] + $signed(atan_turn(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= xq;
      cy_r[0]  <= yq;
      cz_r[0]  <= $signed(z1_r);
      cxr_r[0] <= x1_r;
      cyr_r[0] <= y1_r;
      crr_r[0] <= r1_r;
      cfc_r[0] <= fc1_r;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        cx_r[k+1]  <= cx_nxt[k];
        cy_r[k+1]  <= cy_nxt[k];
        cz_r[k+1]  <= cz_nxt[k];
        cxr_r[k+1] <= cxr_r[k];
        cyr_r[k+1] <= cyr_r[k];
        crr_r[k+1] <= crr_r[k];
        cfc_r[k+1] <= cfc_r[k];
      end
    end
  end

  // drop guard bits, pick rotated or raw vector
  logic signed [CW-1:0]    xd, yd;
  logic signed [ROT_W-1:0] xr_r, yr_r;
  cmd_t                    rr_r;

  always_comb begin
    xd = (cx_r[CORDIC_STEPS] + (CW'(1) << (GUARD - 1))) >>> GUARD;
    yd = (cy_r[CORDIC_STEPS] + (CW'(1) << (GUARD - 1))) >>> GUARD;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr_r <= cfc_r[CORDIC_STEPS] ? xd[ROT_W-1:0] : ROT_W'(cxr_r[CORDIC_STEPS]);
      yr_r <= cfc_r[CORDIC_STEPS] ? yd[ROT_W-1:0] : ROT_W'(cyr_r[CORDIC_STEPS]);
      rr_r <= crr_r[CORDIC_STEPS];
    end
  end

  // wheel mix: front left, rear left, front right, rear right
  logic signed [MIX_W-1:0] xm, ym, rm;
  logic signed [MIX_W-1:0] w_r [0:3];

  assign xm = MIX_W'(xr_r);
  assign ym = MIX_W'(yr_r);
  assign rm = MIX_W'(rr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= xm + ym + rm;
      w_r[1] <= ym - xm + rm;
      w_r[2] <= ym - xm - rm;
      w_r[3] <= xm + ym - rm;
    end
  end

  // magnitudes
  logic [MAG_W-1:0] mag_r [0:3];
  logic             sa_r  [0:3];
  cmd_t             pa_r  [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        mag_r[l] <= w_r[l][MIX_W-1] ? MAG_W'(-w_r[l]) : MAG_W'(w_r[l]);
        sa_r[l]  <= w_r[l][MIX_W-1];
        pa_r[l]  <= w_r[l][CMD_WIDTH-1:0];
      end
    end
  end

  // largest magnitude, two-level compare tree
  logic [MAG_W-1:0] m01, m23, m_nxt, mx_r;
  logic [MAG_W-1:0] magx_r [0:3];
  logic             sx_r   [0:3];
  cmd_t             px_r   [0:3];
  logic             bigx_r;

  always_comb begin
    m01   = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    m23   = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    m_nxt = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r   <= m_nxt;
      bigx_r <= m_nxt > ONE_MAG;
      magx_r <= mag_r;
      sx_r   <= sa_r;
      px_r   <= pa_r;
    end
  end

  // restoring divider, all four wheels in parallel, one quotient bit per stage
  logic [NUM_W-1:0] num [0:3];
  logic [MAG_W-1:0] rem_r [0:3][0:QUO_W];
  logic [QUO_W-1:0] nlo_r [0:3][0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:3][0:QUO_W];
  logic             sd_r  [0:3][0:QUO_W];
  cmd_t             pd_r  [0:3][0:QUO_W];
  logic [MAG_W-1:0] md_r  [0:QUO_W];
  logic             bigd_r [0:QUO_W];
  logic [MAG_W:0]   trial [0:3][0:QUO_W-1];
  logic             take  [0:3][0:QUO_W-1];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      // mag * ONE is mag shifted by FRAC_BITS, plus half the divisor for rounding
      num[l] = ({{QUO_W{1'b0}}, magx_r[l]} << FRAC_BITS) + NUM_W'(mx_r >> 1);
      for (int j = 0; j < QUO_W; j++) begin
        trial[l][j] = {rem_r[l][j], nlo_r[l][j][QUO_W-1]};
        take[l][j]  = trial[l][j] >= {1'b0, md_r[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0]   <= mx_r;
      bigd_r[0] <= bigx_r;
      for (int l = 0; l < 4; l++) begin
        rem_r[l][0] <= num[l][NUM_W-1:QUO_W];
        nlo_r[l][0] <= num[l][QUO_W-1:0];
        quo_r[l][0] <= '0;
        sd_r[l][0]  <= sx_r[l];
        pd_r[l][0]  <= px_r[l];
      end
      for (int j = 0; j < QUO_W; j++) begin
        md_r[j+1]   <= md_r[j];
        bigd_r[j+1] <= bigd_r[j];
        for (int l = 0; l < 4; l++) begin
          rem_r[l][j+1] <= take[l][j] ? MAG_W'(trial[l][j] - {1'b0, md_r[j]})
                                      : trial[l][j][MAG_W-1:0];
          nlo_r[l][j+1] <= nlo_r[l][j] << 1;
          quo_r[l][j+1] <= {quo_r[l][j][QUO_W-2:0], take[l][j]};
          sd_r[l][j+1]  <= sd_r[l][j];
          pd_r[l][j+1]  <= pd_r[l][j];
        end
      end
    end
  end

  // output register: scaled speeds when the largest exceeds one, else the mix as is
  cmd_t spd_nxt [0:3];
  cmd_t spd_r   [0:3];
  cmd_t qs      [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qs[l]      = CMD_WIDTH'(quo_r[l][QUO_W]);
      spd_nxt[l] = bigd_r[QUO_W] ? (sd_r[l][QUO_W] ? -qs[l] : qs[l]) : pd_r[l][QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spd_r <= spd_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.front_left_speed  = spd_r[0];
  assign out_ch.rear_left_speed   = spd_r[1];
  assign out_ch.front_right_speed = spd_r[2];
  assign out_ch.rear_right_speed  = spd_r[3];

  // checks
  localparam cmd_t ONE_CMD = CMD_WIDTH'(ONE);

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_r[0])
    else $error("accepted word did not enter the pipeline");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");

  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (spd_r[0] <= ONE_CMD && spd_r[0] >= -ONE_CMD &&
                     spd_r[1] <= ONE_CMD && spd_r[1] >= -ONE_CMD &&
                     spd_r[2] <= ONE_CMD && spd_r[2] >= -ONE_CMD &&
                     spd_r[3] <= ONE_CMD && spd_r[3] >= -ONE_CMD))
    else $error("wheel speed beyond full scale");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_D0] && bigd_r[0]) |-> (rem_r[0][0] < md_r[0]))
    else $error("divider start remainder not below divisor");

endmodule
`default_nettype wire

// ===== dv/tb_mwm.sv =====
// self-checking testbench of the mecanum wheel mixer
`timescale 1ns / 1ps
module testbench;
  import mwm_pkg::*;

  typedef struct {
    logic signed [15:0] fl, rl, fr, rr;
  } speeds_t;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mwm_in_if  cmd_ch ();
  mwm_out_if spd_ch ();

  mecanum_wheel_mixer dut (.clk(clk), .rst_n(rst_n), .in_ch(cmd_ch), .out_ch(spd_ch));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  speeds_t pending_speeds[$];
  int      errors = 0;
  int      words_sent = 0;
  int      words_checked = 0;
  int      idle_cycles = 0;
  int      fc_words = 0;
  int      clipped_words = 0;

  // floor shift on signed 64-bit values
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return asr(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint turn_angle(int i);
    longint tbl[16] = '{536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886,
                        83443, 41721, 20860};
    return tbl[i];
  endfunction

  // expected wheel speeds for one command word
  function automatic speeds_t mix_wheels(cmd_t sx, cmd_t fy, cmd_t tr, heading_t hd,
                                         logic fc);
    longint x, y, r, t, z, m, dx, dy, mag;
    longint w[4];
    logic [31:0] ph;
    logic [1:0] q;
    speeds_t s;
    x = longint'(sx);
    y = longint'(fy);
    r = longint'(tr);
    if (fc) begin
      ph = {hd, 16'h0};
      q = 2'((ph + 32'h2000_0000) >> 30);
      z = longint'($signed(ph - (32'(q) << 30)));
      x = rnd_shift(x * 652032874, 22);
      y = rnd_shift(y * 652032874, 22);
      case (q)
        2'd1: begin t = x; x = -y; y = t; end
        2'd2: begin x = -x; y = -y; end
        2'd3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      for (int i = 0; i < 16; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= turn_angle(i);
        end else begin
          x += dx; y -= dy; z += turn_angle(i);
        end
      end
      x = rnd_shift(x, 8);
      y = rnd_shift(y, 8);
    end
    w[0] = x + y + r;
    w[1] = -x + y + r;
    w[2] = -x + y - r;
    w[3] = x + y - r;
    m = 0;
    foreach (w[k]) begin
      mag = w[k] < 0 ? -w[k] : w[k];
      if (mag > m) m = mag;
    end
    if (m > ONE) begin
      foreach (w[k]) begin
        mag = w[k] < 0 ? -w[k] : w[k];
        mag = (mag * ONE + m / 2) / m;
        w[k] = w[k] < 0 ? -mag : mag;
      end
    end
    s.fl = 16'(w[0]);
    s.rl = 16'(w[1]);
    s.fr = 16'(w[2]);
    s.rr = 16'(w[3]);
    return s;
  endfunction

  // mostly short gaps, some long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int burst_mode = 0;

  task automatic send_word(cmd_t sx, cmd_t fy, cmd_t tr, heading_t hd, logic fc);
    int g;
    speeds_t e;
    g = burst_mode ? 0 : gap_len();
    repeat (g) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.strafe_cmd    <= sx;
    cmd_ch.forward_cmd   <= fy;
    cmd_ch.turn_cmd      <= tr;
    cmd_ch.heading       <= hd;
    cmd_ch.field_centric <= fc;
    e = mix_wheels(sx, fy, tr, hd, fc);
    do @(posedge clk); while (!cmd_ch.ready);
    pending_speeds.push_back(e);
    words_sent++;
    if (fc) fc_words++;
  endtask

  task automatic end_of_stream();
    cmd_ch.valid <= 1'b0;
  endtask

  // output side: random back-pressure, check every word taken
  initial begin
    spd_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (spd_ch.valid && spd_ch.ready) begin
        speeds_t got, exp_s;
        got = '{spd_ch.front_left_speed, spd_ch.rear_left_speed,
                spd_ch.front_right_speed, spd_ch.rear_right_speed};
        if (pending_speeds.size() == 0) begin
          errors++;
          $display("%0t: unexpected speed word fl=%0d rl=%0d fr=%0d rr=%0d", $time,
                   got.fl, got.rl, got.fr, got.rr);
        end else begin
          exp_s = pending_speeds.pop_front();
          words_checked++;
          if (got.fl != exp_s.fl) begin
            errors++; $display("%0t: fl expected %0d actual %0d", $time, exp_s.fl, got.fl);
          end
          if (got.rl != exp_s.rl) begin
            errors++; $display("%0t: rl expected %0d actual %0d", $time, exp_s.rl, got.rl);
          end
          if (got.fr != exp_s.fr) begin
            errors++; $display("%0t: fr expected %0d actual %0d", $time, exp_s.fr, got.fr);
          end
          if (got.rr != exp_s.rr) begin
            errors++; $display("%0t: rr expected %0d actual %0d", $time, exp_s.rr, got.rr);
          end
          if (exp_s.fl == ONE || exp_s.fl == -ONE || exp_s.fr == ONE || exp_s.fr == -ONE
              || exp_s.rl == ONE || exp_s.rl == -ONE || exp_s.rr == ONE || exp_s.rr == -ONE)
            clipped_words++;
        end
      end
      spd_ch.ready <= burst_mode ? 1'b1 : (gap_len() == 0);
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (spd_ch.valid && spd_ch.ready)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("mecanum_wheel_mixer regression: fail");
      $finish;
    end
  end

  function automatic cmd_t rand_cmd();
    int p;
    p = $urandom_range(9);
    if (p == 0) return cmd_t'($urandom);
    if (p == 1) return $urandom_range(1) ? cmd_t'(ONE) : cmd_t'(-ONE);
    return cmd_t'(int'($urandom_range(2 * ONE)) - ONE);
  endfunction

  task automatic test_extremes();
    send_word('0, '0, '0, '0, 1'b0);
    send_word(cmd_t'(ONE), cmd_t'(ONE), cmd_t'(ONE), '0, 1'b0);
    send_word(cmd_t'(-ONE), cmd_t'(-ONE), cmd_t'(-ONE), '0, 1'b0);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'hffff, 1'b1);
    send_word(16'sh7fff, 16'sh8000, 16'sh7fff, '0, 1'b0);
    send_word(cmd_t'(ONE / 4), cmd_t'(ONE / 4), cmd_t'(ONE / 4), '0, 1'b0);
    send_word(cmd_t'(ONE), '0, '0, 16'h1234, 1'b0);
  endtask

  task automatic test_field_centric();
    // quadrant edges and midpoints of the heading
    heading_t hds[12] = '{16'h0000, 16'h2000, 16'h1fff, 16'h4000, 16'h6000, 16'h8000,
                          16'ha000, 16'hc000, 16'he000, 16'hdfff, 16'h0001, 16'hffff};
    foreach (hds[i]) send_word(cmd_t'(ONE), cmd_t'(ONE / 2), cmd_t'(-ONE / 8), hds[i], 1'b1);
    send_word(16'sh7fff, 16'sh8000, '0, 16'h6000, 1'b1);
  endtask

  task automatic test_random();
    for (int n = 0; n < 600; n++) begin
      burst_mode = (n / 100) % 3 == 2;
      send_word(rand_cmd(), rand_cmd(), rand_cmd(), heading_t'($urandom),
                1'($urandom_range(1)));
    end
    burst_mode = 0;
  endtask

  initial begin
    cmd_ch.valid         <= 1'b0;
    cmd_ch.strafe_cmd    <= '0;
    cmd_ch.forward_cmd   <= '0;
    cmd_ch.turn_cmd      <= '0;
    cmd_ch.heading       <= '0;
    cmd_ch.field_centric <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_field_centric();
    test_random();
    end_of_stream();
    wait (pending_speeds.size() == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d command words (%0d field-centric), checked %0d speed words",
             words_sent, fc_words, words_checked);
    $display("%0d words reached full scale on at least one wheel", clipped_words);
    if (errors == 0) $display("mecanum_wheel_mixer regression: pass");
    else $display("mecanum_wheel_mixer regression: fail");
    $finish;
  end

endmodule
